/* hdl/ptst_pkg.sv */
`default_nettype none
package ptst_pkg;
	localparam int TIME_W = 48;
	localparam int COUNT_W = 32;
	localparam int CORR_W = 17;
	localparam int OCC_W = 16;

	typedef enum logic [1:0] {
		KIND_RECORD = 2'd0,
		KIND_QUERY  = 2'd1,
		KIND_PRUNE  = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_MAX_DELAY = 2'd0,
		REG_MIN_OCC   = 2'd1,
		REG_MIN_CORR  = 2'd2
	} reg_idx_t;
endpackage
`default_nettype wire

/* hdl/ptst_if.sv */
`default_nettype none
interface ptst_in_if #(parameter int PATTERN_BITS = 5);
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [PATTERN_BITS-1:0] pattern_a;
	logic [PATTERN_BITS-1:0] pattern_b;
	logic [47:0] time_us;
	modport source (output valid, kind, pattern_a, pattern_b, time_us, input ready);
	modport sink (input valid, kind, pattern_a, pattern_b, time_us, output ready);
endinterface

interface ptst_out_if #(parameter int DELAY_BITS = 40);
	logic valid;
	logic ready;
	logic found;
	logic [31:0] occurrences;
	logic [DELAY_BITS-1:0] mean_delay_us;
	logic [DELAY_BITS-1:0] spread_us;
	logic [16:0] correlation;
	logic correlated;
	logic [47:0] last_seen_us;
	logic transition_recorded;
	modport source (output valid, found, occurrences, mean_delay_us, spread_us, correlation,
		correlated, last_seen_us, transition_recorded, input ready);
	modport sink (input valid, found, occurrences, mean_delay_us, spread_us, correlation,
		correlated, last_seen_us, transition_recorded, output ready);
endinterface

interface ptst_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [39:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hdl/ptst_ram.sv */
`default_nettype none
module ptst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* hdl/pair_transition_stats_table.sv */
`default_nettype none
// pair transition statistics table. one word in, one result word out per item.
// a record that updates a pair reads its entry, moves the mean by the delay
// difference over the count plus one (not on a first observation), updates
// the spread, with the tenth-weight spread average when it applies, divides
// for the correlation and writes the entry back (the two divisions run one
// quotient bit per cycle on a shared restoring divider, the tenth is a
// shift-add reciprocal in states ST_TEN1 to ST_TEN4). record without update
// and prune go straight to the result, query reads first; clear raises its
// result at once. clear and the pass after reset walk all 2^(2*PATTERN_BITS)
// table entries, one per cycle, taking no items meanwhile. a new word is taken
// from the cycle after a result is accepted; stats sit in one ram, read registered.
module pair_transition_stats_table #(
	parameter int PATTERN_BITS = 5,
	parameter int DELAY_BITS = 40
) (
	input wire logic clk,
	input wire logic arst_n,
	ptst_in_if.sink   in_ch,
	ptst_out_if.source out_ch,
	ptst_cfg_if.sink  cfg
);
	import ptst_pkg::*;

	localparam int AW = 2 * PATTERN_BITS;
	localparam int DEPTH = 1 << AW;
	localparam int ENT_W = COUNT_W + 2 * DELAY_BITS + CORR_W + TIME_W;
	// dividend width covers mean<<16 and |diff|
	localparam int DV_W = DELAY_BITS + 17;
	localparam int DS_W = DELAY_BITS + 1 > 33 ? DELAY_BITS + 1 : 33;
	localparam int CW = $clog2(DV_W + 1);
	localparam int TW = DELAY_BITS + 5;

	typedef enum logic [14:0] {
		ST_WIPE  = 15'h0001,
		ST_IDLE  = 15'h0002,
		ST_READ  = 15'h0004,
		ST_EVAL  = 15'h0008,
		ST_DIV1  = 15'h0010,
		ST_MEAN  = 15'h0020,
		ST_SPRD  = 15'h0040,
		ST_TEN1  = 15'h0080,
		ST_TEN2  = 15'h0100,
		ST_TEN3  = 15'h0200,
		ST_TEN4  = 15'h0400,
		ST_CORR  = 15'h0800,
		ST_DIV2  = 15'h1000,
		ST_WRITE = 15'h2000,
		ST_OUT   = 15'h4000
	} state_t;

	state_t state_q;
	logic [AW-1:0] wipe_q;
	logic [DELAY_BITS-1:0] max_delay_q;
	logic [OCC_W-1:0] min_occ_q;
	logic [CORR_W-1:0] min_corr_q;
	logic [PATTERN_BITS-1:0] last_pat_q;
	logic [TIME_W-1:0] last_time_q;
	logic hist_q;

	logic [1:0] kind_q;
	logic [AW-1:0] idx_q;
	logic [TIME_W-1:0] t_q;
	logic [DELAY_BITS-1:0] d_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [DELAY_BITS-1:0] mean_q, spread_q;
	logic [CORR_W-1:0] corr_q;
	logic [TIME_W-1:0] seen_q;
	logic neg_q;

	// shared restoring divider
	logic [DV_W-1:0] dv_q;
	logic [DS_W-1:0] ds_q;
	logic [DS_W:0] rem_q;
	logic [CW-1:0] dcnt_q;

	// divide by ten: dividend, running estimate, estimate times ten
	logic [TW-1:0] ten_x_q, ten_a_q, ten_m_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [ENT_W-1:0] wdata, rdata;

	ptst_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// a waiting result word holds off the next input word
	assign in_ch.ready = (state_q == ST_IDLE) && !out_ch.valid;
	assign cfg.ready = 1'b1;
	assign raddr = idx_q;
	assign we = (state_q == ST_WIPE) || (state_q == ST_WRITE);
	assign waddr = (state_q == ST_WIPE) ? wipe_q : idx_q;
	assign wdata = (state_q == ST_WIPE) ? '0 : {cnt_q, mean_q, spread_q, corr_q, seen_q};

	logic [COUNT_W-1:0] r_cnt;
	logic [DELAY_BITS-1:0] r_mean, r_spread;
	logic [CORR_W-1:0] r_corr;
	logic [TIME_W-1:0] r_seen;
	assign {r_cnt, r_mean, r_spread, r_corr, r_seen} = rdata;

	logic [TIME_W-1:0] dt;
	assign dt = in_ch.time_us - last_time_q;
	logic [OCC_W-1:0] occ_eff;
	assign occ_eff = (min_occ_q == '0) ? OCC_W'(1) : min_occ_q;

	logic [DS_W:0] rem_sh, rem_sub;
	assign rem_sh = {rem_q[DS_W-1:0], dv_q[DV_W-1]};
	assign rem_sub = rem_sh - {1'b0, ds_q};

	logic [COUNT_W-1:0] cnt_new;
	assign cnt_new = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_W'(1);
	logic [DELAY_BITS-1:0] dev;
	assign dev = (d_q >= mean_q) ? d_q - mean_q : mean_q - d_q;
	logic [DELAY_BITS+4:0] sp9;
	assign sp9 = ({5'd0, spread_q} << 3) + {5'd0, spread_q} + {5'd0, dev};
	logic [DELAY_BITS-1:0] qlo;
	assign qlo = dv_q[DELAY_BITS-1:0];

	// x/10 as x*0.8/8, low by at most one before the remainder fix
	logic [TW-1:0] ten_p1, ten_p2, ten_p3, ten_p4, ten_p5, ten_r;
	assign ten_p1 = (ten_x_q >> 1) + (ten_x_q >> 2);
	assign ten_p2 = ten_p1 + (ten_p1 >> 4);
	assign ten_p3 = ten_a_q + (ten_a_q >> 8);
	assign ten_p4 = ten_p3 + (ten_p3 >> 16);
	assign ten_p5 = (ten_a_q + (ten_a_q >> 32)) >> 3;
	assign ten_r = ten_x_q - ten_m_q;

	// loads the divisor for the correlation divide
	function automatic logic [DS_W-1:0] sum_of(input logic [DELAY_BITS-1:0] m,
		input logic [DELAY_BITS-1:0] s);
		sum_of = DS_W'({1'b0, m} + {1'b0, s});
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
			wipe_q <= '0;
			max_delay_q <= DELAY_BITS'(40'd5000000);
			min_occ_q <= OCC_W'(3);
			min_corr_q <= CORR_W'(32768);
			last_pat_q <= '0;
			last_time_q <= '0;
			hist_q <= 1'b0;
			out_ch.valid <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_MAX_DELAY: max_delay_q <= cfg.data[DELAY_BITS-1:0];
					REG_MIN_OCC: min_occ_q <= cfg.data[OCC_W-1:0];
					REG_MIN_CORR: min_corr_q <= cfg.data[CORR_W-1:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			unique case (state_q)
				ST_WIPE: begin
					wipe_q <= wipe_q + AW'(1);
					if (wipe_q == '1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						kind_q <= in_ch.kind;
						t_q <= in_ch.time_us;
						d_q <= dt[DELAY_BITS-1:0];
						out_ch.found <= 1'b0;
						out_ch.occurrences <= '0;
						out_ch.mean_delay_us <= '0;
						out_ch.spread_us <= '0;
						out_ch.correlation <= '0;
						out_ch.correlated <= 1'b0;
						out_ch.last_seen_us <= '0;
						out_ch.transition_recorded <= 1'b0;
						idx_q <= (in_ch.kind == KIND_RECORD) ? {last_pat_q, in_ch.pattern_a}
							: {in_ch.pattern_a, in_ch.pattern_b};
						case (in_ch.kind)
							KIND_RECORD: begin
								last_pat_q <= in_ch.pattern_a;
								last_time_q <= in_ch.time_us;
								hist_q <= 1'b1;
								if (hist_q && last_pat_q != in_ch.pattern_a
									&& in_ch.time_us >= last_time_q
									&& dt <= TIME_W'(max_delay_q))
									state_q <= ST_READ;
								else
									state_q <= ST_OUT;
							end
							KIND_QUERY: state_q <= ST_READ;
							KIND_PRUNE: begin
								if (last_time_q < in_ch.time_us) hist_q <= 1'b0;
								state_q <= ST_OUT;
							end
							default: begin
								hist_q <= 1'b0;
								wipe_q <= '0;
								state_q <= ST_WIPE;
								out_ch.valid <= 1'b1;
							end
						endcase
					end
				end
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: begin
					if (kind_q == KIND_QUERY) begin
						if (r_cnt != '0 && r_cnt >= COUNT_W'(occ_eff)) begin
							out_ch.found <= 1'b1;
							out_ch.occurrences <= r_cnt;
							out_ch.mean_delay_us <= r_mean;
							out_ch.spread_us <= r_spread;
							out_ch.correlation <= r_corr;
							out_ch.correlated <= r_corr >= min_corr_q;
							out_ch.last_seen_us <= r_seen;
						end
						state_q <= ST_OUT;
					end else if (r_cnt == '0) begin
						cnt_q <= COUNT_W'(1);
						mean_q <= d_q;
						spread_q <= '0;
						state_q <= ST_SPRD;
					end else begin
						cnt_q <= r_cnt;
						mean_q <= r_mean;
						spread_q <= r_spread;
						state_q <= ST_DIV1;
						dcnt_q <= '0;
						rem_q <= '0;
						ds_q <= DS_W'({1'b0, r_cnt} + 33'd1);
						if (d_q >= r_mean) begin
							neg_q <= 1'b0;
							dv_q <= DV_W'(d_q - r_mean);
						end else begin
							neg_q <= 1'b1;
							dv_q <= DV_W'(r_mean - d_q);
						end
					end
				end
				ST_DIV1, ST_DIV2: begin
					dcnt_q <= dcnt_q + CW'(1);
					if (!rem_sub[DS_W]) begin
						rem_q <= rem_sub;
						dv_q <= {dv_q[DV_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						dv_q <= {dv_q[DV_W-2:0], 1'b0};
					end
					if (dcnt_q == CW'(DV_W - 1))
						state_q <= (state_q == ST_DIV1) ? ST_MEAN : ST_WRITE;
				end
				ST_MEAN: begin
					mean_q <= neg_q ? mean_q - qlo : mean_q + qlo;
					cnt_q <= cnt_new;
					state_q <= ST_SPRD;
				end
				ST_SPRD: begin
					seen_q <= t_q;
					if (cnt_q >= COUNT_W'(occ_eff) && spread_q != '0) begin
						ten_x_q <= sp9;
						state_q <= ST_TEN1;
					end else begin
						if (cnt_q >= COUNT_W'(occ_eff)) spread_q <= dev;
						state_q <= ST_CORR;
					end
				end
				ST_TEN1: begin
					ten_a_q <= ten_p2;
					state_q <= ST_TEN2;
				end
				ST_TEN2: begin
					ten_a_q <= ten_p4;
					state_q <= ST_TEN3;
				end
				ST_TEN3: begin
					ten_a_q <= ten_p5;
					ten_m_q <= (ten_p5 << 3) + (ten_p5 << 1);
					state_q <= ST_TEN4;
				end
				ST_TEN4: begin
					spread_q <= DELAY_BITS'((ten_r > TW'(9)) ? ten_a_q + TW'(1) : ten_a_q);
					state_q <= ST_CORR;
				end
				ST_CORR: begin
					dcnt_q <= '0;
					rem_q <= '0;
					dv_q <= DV_W'({mean_q, 16'd0});
					ds_q <= sum_of(mean_q, spread_q);
					state_q <= ST_DIV2;
				end
				ST_WRITE: begin
					state_q <= ST_OUT;
					out_ch.transition_recorded <= 1'b1;
				end
				ST_OUT: begin
					out_ch.valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			// divider output lands in corr_q on its last step
			if (state_q == ST_DIV2 && dcnt_q == CW'(DV_W - 1))
				corr_q <= (mean_q == '0) ? '0
					: (!rem_sub[DS_W] ? {dv_q[CORR_W-2:0], 1'b1} : {dv_q[CORR_W-2:0], 1'b0});
		end
	end

	property p_one_hot;
		@(posedge clk) disable iff (!arst_n) $onehot(state_q);
	endproperty
	a_one_hot: assert property (p_one_hot) else $error("state not one-hot");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");

	a_rec_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.transition_recorded) |-> !out_ch.found)
		else $error("record and query flags together");
endmodule
`default_nettype wire
